>>> hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 256;
  localparam int KEY_W         = 64;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_BYTES_MAX = KEY_W / BYTE_W;

  localparam logic CMD_INIT  = 1'b0;
  localparam logic CMD_CRYPT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // input transfer: latch data byte
    logic fill;        // write identity entry, advance counter
    logic ksa_rd_n;    // read S[n]
    logic ksa_rd_acc;  // accumulate, read S[acc]
    logic ksa_wr_n;    // S[n] <= S[acc]
    logic ksa_wr_acc;  // S[acc] <= t, advance counter
    logic cr_rd_i;     // i <= i + 1, read S[i]
    logic cr_rd_j;     // j <= j + a, read S[j]
    logic cr_wr_i;     // S[i] <= b, read S[a + b]
    logic cr_wr_j;     // S[j] <= a
    logic out_load;    // load output byte
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
  } sts_t;

endpackage

>>> hdl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher with an 8-byte key register and a shared crypt path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, cmd, data_in): cmd 0 runs the key
//   schedule from cipher key, cmd 1 XORs data_in with the next keystream byte.
//   Output channel (out_valid/out_stall, data_out): one transfer per crypt
//   item, none for an init item.
//   cfg_wr_en/cfg_wr_data load the key; write it only while the block is idle.
//   A crypt item runs four steps on the permutation memory, which has one
//   read port and one write port (read S[i], read S[j], write S[i], write
//   S[j]); the result shows at the end of the fourth step.
//   An init item runs an identity fill of all 256 entries, then 256 swap
//   steps, all through the one memory write port.
//   After reset the block runs the same identity fill with in_stall high,
//   clears both indices and the key, then waits for items.
//   The result sits in an output register; while out_stall holds it, a
//   finished crypt step waits in its last state and accepts nothing new.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rc4_pkg::KEY_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [rc4_pkg::BYTE_W-1:0]  data_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rc4_pkg::BYTE_W-1:0]  data_out
);

  rc4_pkg::ctl_t ctl;
  rc4_pkg::sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  rc4_dpath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_in     (data_in),
    .data_out    (data_out),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule

>>> hdl/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the RC4 block: clearing pass, key schedule and crypt steps,
// input and output handshakes.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output rc4_pkg::ctl_t ctl,
  input  rc4_pkg::sts_t sts
);

  typedef enum logic [9:0] {
    ST_FILL       = 10'b00_0000_0001,
    ST_IDLE       = 10'b00_0000_0010,
    ST_K_RD_N     = 10'b00_0000_0100,
    ST_K_RD_ACC   = 10'b00_0000_1000,
    ST_K_WR_N     = 10'b00_0001_0000,
    ST_K_WR_ACC   = 10'b00_0010_0000,
    ST_C_RD_I     = 10'b00_0100_0000,
    ST_C_RD_J     = 10'b00_1000_0000,
    ST_C_WR_I     = 10'b01_0000_0000,
    ST_C_WR_J     = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ksa_pend;
  logic   ksa_pend_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    ksa_pend_next  = ksa_pend;
    ctl.capture    = accept;
    unique case (state)
      ST_FILL: begin
        ctl.fill = 1'b1;
        if (sts.cnt_last) begin
          state_next    = ksa_pend ? ST_K_RD_N : ST_IDLE;
          ksa_pend_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd == rc4_pkg::CMD_CRYPT) begin
            state_next = ST_C_RD_I;
          end else begin
            state_next    = ST_FILL;
            ksa_pend_next = 1'b1;
          end
        end
      end
      ST_K_RD_N: begin
        ctl.ksa_rd_n = 1'b1;
        state_next   = ST_K_RD_ACC;
      end
      ST_K_RD_ACC: begin
        ctl.ksa_rd_acc = 1'b1;
        state_next     = ST_K_WR_N;
      end
      ST_K_WR_N: begin
        ctl.ksa_wr_n = 1'b1;
        state_next   = ST_K_WR_ACC;
      end
      ST_K_WR_ACC: begin
        ctl.ksa_wr_acc = 1'b1;
        state_next     = sts.cnt_last ? ST_IDLE : ST_K_RD_N;
      end
      ST_C_RD_I: begin
        ctl.cr_rd_i = 1'b1;
        state_next  = ST_C_RD_J;
      end
      ST_C_RD_J: begin
        ctl.cr_rd_j = 1'b1;
        state_next  = ST_C_WR_I;
      end
      ST_C_WR_I: begin
        ctl.cr_wr_i = 1'b1;
        state_next  = ST_C_WR_J;
      end
      ST_C_WR_J: begin
        ctl.cr_wr_j = 1'b1;
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      ksa_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ksa_pend <= ksa_pend_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(out_valid && out_stall))
    else $error("output loaded over a pending transfer");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ksa_pend)
    else $error("idle with key schedule pending");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_C_WR_J))
    else $error("output valid without crypt step");
`endif

endmodule

>>> hdl/rc4_dpath.sv
// ----------------------------------------------------------------------------
// rc4_dpath
// RC4 datapath: permutation memory, indices, key register and output byte.
// ----------------------------------------------------------------------------
module rc4_dpath #(
  parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rc4_pkg::KEY_W-1:0]   cfg_wr_data,
  input  logic [rc4_pkg::BYTE_W-1:0]  data_in,
  output logic [rc4_pkg::BYTE_W-1:0]  data_out,
  input  rc4_pkg::ctl_t               ctl,
  output rc4_pkg::sts_t               sts
);

  localparam int AW     = $clog2(rc4_pkg::PERM_DEPTH);
  localparam int KPOS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KSEL_W = $clog2(rc4_pkg::KEY_BYTES_MAX);
  localparam logic [KPOS_W-1:0] KPOS_LAST = KPOS_W'(KEY_BYTES - 1);

  logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] rdata;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic [rc4_pkg::BYTE_W-1:0] wdata;
  logic                       we;

  logic [rc4_pkg::KEY_W-1:0]  cipher_key;
  logic [AW-1:0]              cnt;
  logic [KPOS_W-1:0]          kpos;
  logic [AW-1:0]              acc;
  logic [AW-1:0]              acc_next;
  logic [AW-1:0]              idx_i;
  logic [AW-1:0]              idx_j;
  logic [AW-1:0]              j_next;
  logic [AW-1:0]              ks_addr;
  logic [rc4_pkg::BYTE_W-1:0] val_a;
  logic [rc4_pkg::BYTE_W-1:0] val_b;
  logic [rc4_pkg::BYTE_W-1:0] data_reg;
  logic [rc4_pkg::BYTE_W-1:0] key_byte;
  logic [rc4_pkg::BYTE_W-1:0] ks;

  assign sts.cnt_last = (cnt == AW'(rc4_pkg::PERM_DEPTH - 1));

  assign key_byte = rc4_pkg::BYTE_W'(cipher_key >> {KSEL_W'(kpos), 3'b000});
  assign acc_next = acc + rdata + key_byte;
  assign j_next   = idx_j + rdata;
  assign ks_addr  = val_a + val_b;

  always_comb begin
    priority if (ks_addr == idx_j) begin
      ks = val_a;
    end else if (ks_addr == idx_i) begin
      ks = val_b;
    end else begin
      ks = rdata;
    end
  end

  always_comb begin
    raddr = cnt;
    waddr = cnt;
    wdata = rc4_pkg::BYTE_W'(cnt);
    we    = 1'b0;
    priority if (ctl.fill) begin
      we = 1'b1;
    end else if (ctl.ksa_rd_n) begin
      raddr = cnt;
    end else if (ctl.ksa_rd_acc) begin
      raddr = acc_next;
    end else if (ctl.ksa_wr_n) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (ctl.ksa_wr_acc) begin
      we    = 1'b1;
      waddr = acc;
      wdata = val_a;
    end else if (ctl.cr_rd_i) begin
      raddr = idx_i + AW'(1);
    end else if (ctl.cr_rd_j) begin
      raddr = j_next;
    end else if (ctl.cr_wr_i) begin
      we    = 1'b1;
      waddr = idx_i;
      wdata = rdata;
      raddr = val_a + rdata;
    end else if (ctl.cr_wr_j) begin
      we    = 1'b1;
      waddr = idx_j;
      wdata = val_a;
      raddr = ks_addr;
    end else begin
      raddr = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      cnt        <= '0;
      kpos       <= '0;
      acc        <= '0;
      idx_i      <= '0;
      idx_j      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cipher_key <= cfg_wr_data;
      end
      if (ctl.fill) begin
        cnt   <= cnt + AW'(1);
        kpos  <= '0;
        acc   <= '0;
        idx_i <= '0;
        idx_j <= '0;
      end
      if (ctl.ksa_rd_acc) begin
        acc <= acc_next;
      end
      if (ctl.ksa_wr_acc) begin
        cnt  <= cnt + AW'(1);
        kpos <= (kpos == KPOS_LAST) ? '0 : kpos + KPOS_W'(1);
      end
      if (ctl.cr_rd_i) begin
        idx_i <= idx_i + AW'(1);
      end
      if (ctl.cr_rd_j) begin
        idx_j <= j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      data_reg <= data_in;
    end
    if (ctl.ksa_rd_acc || ctl.cr_rd_j) begin
      val_a <= rdata;
    end
    if (ctl.cr_wr_i) begin
      val_b <= rdata;
    end
    if (ctl.out_load) begin
      data_out <= data_reg ^ ks;
    end
  end

`ifndef SYNTH
  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (ctl.fill && sts.cnt_last) |=> (cnt == '0 && idx_i == '0 && idx_j == '0))
    else $error("clearing pass did not leave counter and indices at zero");

  a_ksa_wrap: assert property (@(posedge clk) disable iff (rst)
    (ctl.ksa_wr_acc && sts.cnt_last) |=> (cnt == '0))
    else $error("key schedule counter did not wrap");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rc4_stream_cipher. A directed table covers the
// generator before any key schedule, key extremes, a key change without a
// new schedule, and back-to-back schedules. Randomized phases follow, cycling
// through four flow-control mixes; all but every third load a new key. Every
// output transfer is checked against the table value if given, else against
// an in-bench RC4 predictor that tracks the permutation and both indices.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int INIT_SETTLE  = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 12;
  localparam int MAX_REPORTS  = 50;
  localparam int NUM_DIRECTED = 22;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

  typedef struct {
    bit                          load_key;
    logic [rc4_pkg::KEY_W-1:0]   key;
    logic                        op;
    logic [rc4_pkg::BYTE_W-1:0]  data;
    bit                          known;
    logic [rc4_pkg::BYTE_W-1:0]  want;
  } vec_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en;
  logic [rc4_pkg::KEY_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       cmd;
  logic [rc4_pkg::BYTE_W-1:0] data_in;
  logic                       out_valid;
  logic                       out_stall;
  logic [rc4_pkg::BYTE_W-1:0] data_out;

  rc4_stream_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out)
  );

  always #HALF_PERIOD clk = ~clk;

  // predictor state
  logic [rc4_pkg::BYTE_W-1:0] sbox [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] gen_i = '0;
  logic [rc4_pkg::BYTE_W-1:0] gen_j = '0;
  logic [rc4_pkg::KEY_W-1:0]  key_shadow = '0;
  logic [rc4_pkg::BYTE_W-1:0] cipher_q [$];

  // driver to monitor: typed expectation for the item on the bus
  bit                         cur_known;
  logic [rc4_pkg::BYTE_W-1:0] cur_want;

  int src_pct;
  int snk_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  int fail_cnt;
  int n_items;
  int n_inits;
  int n_checked;
  int n_keys;
  int cycles;

  vec_t dir_vecs [NUM_DIRECTED] = '{
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h00, 1, 8'h02},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hFF, 1, 8'hFA},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hA5, 1, 8'hA2},
    '{0, '0, rc4_pkg::CMD_INIT,  8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hFF, 0, 8'h00},
    '{1, 64'hFFFF_FFFF_FFFF_FFFF, rc4_pkg::CMD_INIT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h55, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hAA, 0, 8'h00},
    '{1, 64'h0706_0504_0302_0100, rc4_pkg::CMD_INIT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h80, 0, 8'h00},
    '{1, 64'h0808_0808_0808_0808, rc4_pkg::CMD_CRYPT, 8'h01, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h7F, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_INIT,  8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hFF, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_INIT,  8'hFF, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_INIT,  8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'h3C, 0, 8'h00},
    '{1, 64'h0123_4567_89AB_CDEF, rc4_pkg::CMD_INIT, 8'h00, 0, 8'h00},
    '{0, '0, rc4_pkg::CMD_CRYPT, 8'hC3, 0, 8'h00}
  };

  function automatic void schedule_key();
    logic [rc4_pkg::BYTE_W-1:0] acc;
    logic [rc4_pkg::BYTE_W-1:0] t;
    int n;
    acc = '0;
    for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = n[rc4_pkg::BYTE_W-1:0];
    for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      t = sbox[n];
      acc = acc + t + key_shadow[rc4_pkg::BYTE_W*(n % rc4_pkg::KEY_BYTES_DEF)
                                 +: rc4_pkg::BYTE_W];
      sbox[n] = sbox[acc];
      sbox[acc] = t;
    end
    gen_i = '0;
    gen_j = '0;
  endfunction

  function automatic logic [rc4_pkg::BYTE_W-1:0] next_cipher_byte(
    logic [rc4_pkg::BYTE_W-1:0] d
  );
    logic [rc4_pkg::BYTE_W-1:0] a;
    logic [rc4_pkg::BYTE_W-1:0] b;
    logic [rc4_pkg::BYTE_W-1:0] ab;
    gen_i = gen_i + 8'd1;
    a = sbox[gen_i];
    gen_j = gen_j + a;
    b = sbox[gen_j];
    sbox[gen_i] = b;
    sbox[gen_j] = a;
    ab = a + b;
    return d ^ sbox[ab];
  endfunction

  initial begin
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = n[rc4_pkg::BYTE_W-1:0];
  end

  // monitor: predicts on input transfers, checks output transfers
  logic [rc4_pkg::BYTE_W-1:0] pred_b;
  logic [rc4_pkg::BYTE_W-1:0] want_b;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        n_items++;
        if (cmd == rc4_pkg::CMD_INIT) begin
          schedule_key();
          n_inits++;
        end else begin
          pred_b = next_cipher_byte(data_in);
          cipher_q.push_back(cur_known ? cur_want : pred_b);
        end
      end
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $error("data_out transfer with nothing pending: actual %02h", data_out);
        end else begin
          want_b = cipher_q.pop_front();
          n_checked++;
          if (data_out !== want_b) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $error("data_out: expected %02h, actual %02h", want_b, data_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("rc4_stream_cipher regression: fail");
      $finish;
    end
  end

  // receiver: random stall, plus long hold-offs on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_seen != hold_reqs) begin
        hold_seen++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (snk_pct != 0) && ($urandom_range(99) < snk_pct);
      end
    end
  end

  task automatic send_item(logic op, logic [rc4_pkg::BYTE_W-1:0] d, bit known,
                           logic [rc4_pkg::BYTE_W-1:0] want);
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    data_in   <= d;
    cur_known <= known;
    cur_want  <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (cipher_q.size() != 0) @(negedge clk);
  endtask

  task automatic load_key(logic [rc4_pkg::KEY_W-1:0] k);
    wait_results();
    repeat (INIT_SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    key_shadow = k;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_keys++;
  endtask

  initial begin
    flow_t flow;
    int len;
    logic [rc4_pkg::KEY_W-1:0] k;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    cmd         = rc4_pkg::CMD_INIT;
    data_in     = '0;
    cur_known   = 1'b0;
    cur_want    = '0;
    src_pct     = 0;
    snk_pct     = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_vecs[v]) begin
      if (dir_vecs[v].load_key) load_key(dir_vecs[v].key);
      send_item(dir_vecs[v].op, dir_vecs[v].data, dir_vecs[v].known, dir_vecs[v].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      flow = flow_t'(ph % 4);
      case (flow)
        FLOW_FREE:      begin src_pct = 0;  snk_pct = 0;  end
        FLOW_SRC_IDLE:  begin src_pct = 58; snk_pct = 0;  end
        FLOW_SNK_STALL: begin src_pct = 0;  snk_pct = 58; end
        default:        begin src_pct = 9;  snk_pct = 9;  end
      endcase
      if (ph % 3 != 2) begin
        case (ph)
          0:       k = '0;
          1:       k = '1;
          default: k = {$urandom, $urandom};
        endcase
        load_key(k);
        send_item(rc4_pkg::CMD_INIT, 8'($urandom), 1'b0, '0);
      end
      len = $urandom_range(120, 60);
      for (int n = 0; n < len; n++) begin
        if (flow == FLOW_FREE && n == len / 3) hold_reqs++;
        if (flow == FLOW_SRC_IDLE && n == len / 2) wait_results();
        if ($urandom_range(63) == 0)
          send_item(rc4_pkg::CMD_INIT, 8'($urandom), 1'b0, '0);
        else
          send_item(rc4_pkg::CMD_CRYPT, 8'($urandom), 1'b0, '0);
      end
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items transferred (%0d key schedules), %0d cipher bytes checked",
             n_items, n_inits, n_checked);
    $display("%0d key loads across %0d flow-control phases", n_keys, PHASES);
    if (fail_cnt == 0)
      $display("rc4_stream_cipher regression: pass");
    else
      $display("rc4_stream_cipher regression: fail");
    $finish;
  end

endmodule

>>> rc4_stream_cipher.f
hdl/rc4_pkg.sv
hdl/rc4_ctrl.sv
hdl/rc4_dpath.sv
hdl/rc4_stream_cipher.sv
tb/tb_top.sv
